// ===== hw/rtl/fa_pkg.sv =====
// Package: field widths, defaults and operation codes of the fraction accumulator ALU.
`default_nettype none
package fa_pkg;

  localparam int FIELD_W        = 32;
  localparam int FUNC_W         = 3;
  localparam int WORD_WIDTH_DEF = 32;

  localparam logic [FUNC_W-1:0] FN_LOAD   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SUB    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MUL    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DIV    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_REDUCE = 3'd5;

endpackage
`default_nettype wire

// ===== hw/rtl/fa_channels.sv =====
// Interfaces: operation item channel and result item channel.
`default_nettype none
interface fa_in_if import fa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [FIELD_W-1:0] operand_num;
  logic signed [FIELD_W-1:0] operand_den;

  modport source(output valid, func, operand_num, operand_den, input ready);
  modport sink(input valid, func, operand_num, operand_den, output ready);
endinterface

interface fa_out_if import fa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] result_num;
  logic signed [FIELD_W-1:0] result_den;
  logic                      den_zero;

  modport source(output valid, result_num, result_den, den_zero, input ready);
  modport sink(input valid, result_num, result_den, den_zero, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fa_addsub.sv =====
// Shared adder/subtractor with carry out; carry on subtract means op_a >= op_b.
`default_nettype none
module fa_addsub #(
  parameter int W = 32
) (
  input  wire logic [W-1:0] op_a,
  input  wire logic [W-1:0] op_b,
  input  wire logic         sub,
  output logic      [W:0]   sum
);

  logic [W-1:0] op_b_x;

  assign op_b_x = op_b ^ {W{sub}};
  assign sum    = {1'b0, op_a} + {1'b0, op_b_x} + (W+1)'(sub);

endmodule
`default_nettype wire

// ===== hw/rtl/fraction_accumulator_alu.sv =====
// Top level: fraction accumulator with load, add, subtract, multiply, divide and reduce.
//
// The block holds a fraction num/den of WORD_WIDTH bits each and applies one operation per
// item, returning the new fraction and a zero-denominator flag. All work runs through one
// shared WORD_WIDTH-bit adder/subtractor under a sequencer, and the block takes no new item
// until the current one is finished; a finished result waits in an output register, so the
// next item is taken while it is still pending. Load and unused codes go straight to the
// output; add/subtract with equal denominators adds or subtracts the numerators directly;
// multiply and divide form two products in the shift-add multiplier (one multiplier bit
// per cycle, ending early when the remaining bits are zero); add/subtract with unequal
// denominators forms three; reduce runs a binary GCD of the magnitudes, then two restoring
// divisions (one quotient bit per cycle) of the magnitudes by it, restoring the signs.
`default_nettype none
module fraction_accumulator_alu import fa_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  fa_in_if.sink    in_chan,
  fa_out_if.source out_chan
);

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_MSET   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_COMB   = 4'd4;
  localparam logic [3:0] S_RA     = 4'd5;
  localparam logic [3:0] S_RB     = 4'd6;
  localparam logic [3:0] S_GTWO   = 4'd7;
  localparam logic [3:0] S_GXODD  = 4'd8;
  localparam logic [3:0] S_GLOOP  = 4'd9;
  localparam logic [3:0] S_GSHIFT = 4'd10;
  localparam logic [3:0] S_DSET   = 4'd11;
  localparam logic [3:0] S_DIVS   = 4'd12;
  localparam logic [3:0] S_NEGQ   = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  localparam logic [1:0] JOB_FIRST = 2'd0;
  localparam logic [1:0] JOB_CROSS = 2'd1;
  localparam logic [1:0] JOB_DEN   = 2'd2;

  logic [3:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [W-1:0]      a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [W-1:0]      x_r, x_nxt, y_r, y_nxt, p_r, p_nxt, m_r, m_nxt;
  logic [W-1:0]      t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]        jb_r, jb_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [FIELD_W-1:0] out_num_r, out_num_nxt, out_den_r, out_den_nxt;
  logic              out_zero_r, out_zero_nxt;

  logic [W-1:0] op_a, op_b;
  logic         op_sub;
  logic [W:0]   sum;
  logic [W-1:0] rsh;
  logic [W-1:0] qv;
  logic         addsub;

  fa_addsub #(.W(W)) u_addsub (
    .op_a (op_a),
    .op_b (op_b),
    .sub  (op_sub),
    .sum  (sum)
  );

  assign rsh    = {p_r[W-2:0], m_r[W-1]};
  assign addsub = (func_r == FN_ADD) || (func_r == FN_SUB);
  assign qv     = ((jb_r == JOB_FIRST) ? a_r[W-1] : b_r[W-1]) ? sum[W-1:0] : m_r;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state_r)
      S_MUL: begin
        op_a = p_r;
        op_b = x_r;
      end
      S_COMB: begin
        op_a   = t1_r;
        op_b   = t2_r;
        op_sub = (func_r == FN_SUB);
      end
      S_RA: begin
        op_b   = a_r;
        op_sub = 1'b1;
      end
      S_RB: begin
        op_b   = b_r;
        op_sub = 1'b1;
      end
      S_GLOOP: begin
        op_a   = y_r;
        op_b   = x_r;
        op_sub = 1'b1;
      end
      S_DIVS: begin
        op_a   = rsh;
        op_b   = x_r;
        op_sub = 1'b1;
      end
      S_NEGQ: begin
        op_b   = m_r;
        op_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    t3_nxt        = t3_r;
    cnt_nxt       = cnt_r;
    jb_nxt        = jb_r;
    out_valid_nxt = out_valid_r;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;
    out_zero_nxt  = out_zero_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          func_nxt  = in_chan.func;
          c_nxt     = W'(in_chan.operand_num);
          d_nxt     = W'(in_chan.operand_den);
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        jb_nxt = JOB_FIRST;
        unique case (func_r)
          FN_LOAD: begin
            a_nxt     = c_r;
            b_nxt     = d_r;
            state_nxt = S_FIN;
          end
          FN_ADD, FN_SUB: begin
            if (b_r == d_r) begin
              t1_nxt    = a_r;
              t2_nxt    = c_r;
              t3_nxt    = b_r;
              state_nxt = S_COMB;
            end else begin
              state_nxt = S_MSET;
            end
          end
          FN_MUL, FN_DIV: state_nxt = S_MSET;
          FN_REDUCE: begin
            state_nxt = ((a_r == '0) || (b_r == '0)) ? S_FIN : S_RA;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_MSET: begin
        p_nxt = '0;
        unique case (jb_r)
          JOB_FIRST: begin
            x_nxt = a_r;
            m_nxt = (func_r == FN_MUL) ? c_r : d_r;
          end
          JOB_CROSS: begin
            x_nxt = b_r;
            m_nxt = c_r;
          end
          default: begin
            x_nxt = b_r;
            m_nxt = (func_r == FN_DIV) ? c_r : d_r;
          end
        endcase
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (m_r == '0) begin
          unique case (jb_r)
            JOB_FIRST: begin
              t1_nxt    = p_r;
              jb_nxt    = addsub ? JOB_CROSS : JOB_DEN;
              state_nxt = S_MSET;
            end
            JOB_CROSS: begin
              t2_nxt    = p_r;
              jb_nxt    = JOB_DEN;
              state_nxt = S_MSET;
            end
            default: begin
              if (addsub) begin
                t3_nxt    = p_r;
                state_nxt = S_COMB;
              end else begin
                a_nxt     = t1_r;
                b_nxt     = p_r;
                state_nxt = S_FIN;
              end
            end
          endcase
        end else begin
          if (m_r[0]) begin
            p_nxt = sum[W-1:0];
          end
          x_nxt = x_r << 1;
          m_nxt = m_r >> 1;
        end
      end
      S_COMB: begin
        a_nxt     = sum[W-1:0];
        b_nxt     = t3_r;
        state_nxt = S_FIN;
      end
      S_RA: begin
        x_nxt     = a_r[W-1] ? sum[W-1:0] : a_r;
        t1_nxt    = a_r[W-1] ? sum[W-1:0] : a_r;
        state_nxt = S_RB;
      end
      S_RB: begin
        y_nxt     = b_r[W-1] ? sum[W-1:0] : b_r;
        t2_nxt    = b_r[W-1] ? sum[W-1:0] : b_r;
        cnt_nxt   = '0;
        state_nxt = S_GTWO;
      end
      S_GTWO: begin
        if (!x_r[0] && !y_r[0]) begin
          x_nxt   = x_r >> 1;
          y_nxt   = y_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = S_GXODD;
        end
      end
      S_GXODD: begin
        if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else begin
          state_nxt = S_GLOOP;
        end
      end
      S_GLOOP: begin
        priority if (y_r == '0) begin
          state_nxt = S_GSHIFT;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (sum[W]) begin
          y_nxt = sum[W-1:0];
        end else begin
          x_nxt = y_r;
          y_nxt = x_r;
        end
      end
      S_GSHIFT: begin
        if (cnt_r != '0) begin
          x_nxt   = x_r << 1;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          jb_nxt    = JOB_FIRST;
          state_nxt = S_DSET;
        end
      end
      S_DSET: begin
        m_nxt     = (jb_r == JOB_FIRST) ? t1_r : t2_r;
        p_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        p_nxt = sum[W] ? sum[W-1:0] : rsh;
        m_nxt = {m_r[W-2:0], sum[W]};
        if (cnt_r == CW'(W - 1)) begin
          state_nxt = S_NEGQ;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_NEGQ: begin
        if (jb_r == JOB_FIRST) begin
          a_nxt     = qv;
          jb_nxt    = JOB_CROSS;
          state_nxt = S_DSET;
        end else begin
          b_nxt     = qv;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_num_nxt   = FIELD_W'(signed'(a_r));
          out_den_nxt   = FIELD_W'(signed'(b_r));
          out_zero_nxt  = (b_r == '0);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_r         <= '0;
      b_r         <= W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    p_r        <= p_nxt;
    m_r        <= m_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    t3_r       <= t3_nxt;
    cnt_r      <= cnt_nxt;
    jb_r       <= jb_nxt;
    out_num_r  <= out_num_nxt;
    out_den_r  <= out_den_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.result_num = out_num_r;
  assign out_chan.result_den = out_den_r;
  assign out_chan.den_zero   = out_zero_r;

endmodule
`default_nettype wire
